>>> sv/grbf_pkg.sv
// Shared types, constants and lookup functions for the Gaussian RBF evaluator.
// No dependencies; imported by every module of the block.
`default_nettype none
package grbf_pkg;

  // Fixed-point format of the Q16.16 values; the Q30 and Q29 constants below differ
  localparam int FRAC_BITS = 16;
  localparam logic [31:0] Q_ONE = 32'd1 << FRAC_BITS;

  localparam logic [30:0] ONE_Q30     = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] TWO_PI_Q29  = 32'd3373259426;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [4:0] CORDIC_LAST = 5'd29;
  localparam logic [4:0] EXP_LAST    = 5'd20;

  // Item function codes
  localparam logic [1:0] FUNC_EVAL        = 2'd0;
  localparam logic [1:0] FUNC_LOAD_POINT  = 2'd1;
  localparam logic [1:0] FUNC_LOAD_WEIGHT = 2'd2;

  typedef enum logic [2:0] {
    REG_TIME_WINDOW, REG_FREQUENCY, REG_AMP_SCALE, REG_BASIS_PARAM,
    REG_X_BOUNDS, REG_Y_BOUNDS, REG_Z_BOUNDS, REG_POINT_COUNT
  } reg_idx_t;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_BOUNDS, OP_RD, OP_DIFF, OP_SQX, OP_SQY, OP_PLO,
    OP_PHI, OP_ACHK, OP_EXP, OP_WACC, OP_PHASE, OP_ZINIT, OP_CORDIC, OP_FOLD,
    OP_AS, OP_AC, OP_OMEGA, OP_VMUL, OP_DLO, OP_DHI, OP_DFIN, OP_VLO, OP_VHI,
    OP_VFIN, OP_OUT
  } op_t;

  typedef struct packed {
    logic       capture;
    op_t        op;
    logic [5:0] idx;
    logic [4:0] step;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       dom;
  } sts_t;

  typedef struct packed {
    logic [31:0] t_start;
    logic [31:0] t_end;
    logic [31:0] freq;
    logic [31:0] amp;
    logic [31:0] basis;
    logic [31:0] x_min;
    logic [31:0] x_max;
    logic [31:0] y_min;
    logic [31:0] y_max;
    logic [31:0] z_min;
    logic [31:0] z_max;
    logic [5:0]  pcount;
  } cfg_t;

  // CORDIC rotation angle for step i, Q30 radians
  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] v;
    case (i)
      5'd0: v = 31'd843314857;
      5'd1: v = 31'd497837829;
      5'd2: v = 31'd263043837;
      5'd3: v = 31'd133525159;
      5'd4: v = 31'd67021687;
      5'd5: v = 31'd33543516;
      5'd6: v = 31'd16775851;
      5'd7: v = 31'd8388437;
      5'd8: v = 31'd4194283;
      5'd9: v = 31'd2097149;
      default: v = 31'd1 << (5'd30 - i);
    endcase
    return v;
  endfunction

  // exp factor for exponent-walk step s: fraction bits first, then whole bits
  function automatic logic [30:0] exp_factor(input logic [4:0] s);
    logic [30:0] v;
    case (s)
      5'd0:  v = 31'd651257337;
      5'd1:  v = 31'd836230973;
      5'd2:  v = 31'd947573834;
      5'd3:  v = 31'd1008687096;
      5'd4:  v = 31'd1040706261;
      5'd5:  v = 31'd1057095000;
      5'd6:  v = 31'd1065385899;
      5'd7:  v = 31'd1069555701;
      5'd8:  v = 31'd1071646719;
      5'd9:  v = 31'd1072693760;
      5'd10: v = 31'd1073217664;
      5'd11: v = 31'd1073479712;
      5'd12: v = 31'd1073610760;
      5'd13: v = 31'd1073676290;
      5'd14: v = ONE_Q30 - 31'd32768;
      5'd15: v = ONE_Q30 - 31'd16384;
      5'd16: v = 31'd395007542;
      5'd17: v = 31'd145315153;
      5'd18: v = 31'd19666267;
      5'd19: v = 31'd360200;
      5'd20: v = 31'd121;
      default: v = ONE_Q30;
    endcase
    return v;
  endfunction

  // Apply a sign to a magnitude and saturate to 32 bits
  function automatic logic [31:0] sat_signed(input logic neg, input logic [71:0] m);
    logic [31:0] v;
    if (neg) begin
      v = (m[71:31] != '0) ? 32'h8000_0000 : -m[31:0];
    end else begin
      v = (m[71:31] != '0) ? 32'h7FFF_FFFF : m[31:0];
    end
    return v;
  endfunction

endpackage
`default_nettype wire

>>> sv/grbf_regs.sv
// Configuration register file of the RBF evaluator.
// Depends on grbf_pkg for the register index codes and the cfg_t bundle.
`default_nettype none
module grbf_regs import grbf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t cfg_r;

  // Take one register beat per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      cfg_r.basis <= Q_ONE;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_TIME_WINDOW: begin
          cfg_r.t_start <= cfg_data[31:0];
          cfg_r.t_end   <= cfg_data[63:32];
        end
        REG_FREQUENCY:   cfg_r.freq  <= cfg_data[31:0];
        REG_AMP_SCALE:   cfg_r.amp   <= cfg_data[31:0];
        REG_BASIS_PARAM: cfg_r.basis <= cfg_data[31:0];
        REG_X_BOUNDS: begin
          cfg_r.x_min <= cfg_data[31:0];
          cfg_r.x_max <= cfg_data[63:32];
        end
        REG_Y_BOUNDS: begin
          cfg_r.y_min <= cfg_data[31:0];
          cfg_r.y_max <= cfg_data[63:32];
        end
        REG_Z_BOUNDS: begin
          cfg_r.z_min <= cfg_data[31:0];
          cfg_r.z_max <= cfg_data[63:32];
        end
        REG_POINT_COUNT: cfg_r.pcount <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> sv/grbf_ctrl.sv
// Sequencing state machine of the RBF evaluator: walks the control points,
// the exp steps and the CORDIC steps. Depends on grbf_pkg.
`default_nettype none
module grbf_ctrl import grbf_pkg::*; #(
  parameter int MAX_POINTS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [5:0] pcount,
  input  sts_t            sts,
  output cmd_t            cmd,
  output logic            busy
);

  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_LOAD, S_BOUNDS, S_CHECK, S_RD, S_DIFF, S_SQX, S_SQY,
    S_PLO, S_PHI, S_ACHK, S_EXP, S_WACC, S_PHASE, S_ZINIT, S_CORDIC, S_FOLD,
    S_AS, S_AC, S_OMEGA, S_VMUL, S_DLO, S_DHI, S_DFIN, S_VLO, S_VHI, S_VFIN,
    S_OUT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt, n_pts;
  logic [4:0]    step_r, step_nxt;
  logic          busy_r;

  // Clamp the point count to the store depth
  always_comb begin
    if (int'(pcount) > MAX_POINTS) n_pts = CW'(MAX_POINTS);
    else n_pts = CW'(pcount);
  end

  // Next state and counters
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = S_DECODE;
      S_DECODE: begin
        if (sts.func == FUNC_EVAL) state_nxt = S_BOUNDS;
        else if (sts.func == FUNC_LOAD_POINT || sts.func == FUNC_LOAD_WEIGHT)
          state_nxt = S_LOAD;
        else state_nxt = S_OUT;
      end
      S_LOAD:   state_nxt = S_OUT;
      S_BOUNDS: state_nxt = S_CHECK;
      S_CHECK: begin
        idx_nxt = '0;
        if (!sts.dom) state_nxt = S_OUT;
        else if (n_pts == '0) state_nxt = S_PHASE;
        else state_nxt = S_RD;
      end
      S_RD:   state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_SQX;
      S_SQX:  state_nxt = S_SQY;
      S_SQY:  state_nxt = S_PLO;
      S_PLO:  state_nxt = S_PHI;
      S_PHI:  state_nxt = S_ACHK;
      S_ACHK: begin
        step_nxt  = '0;
        state_nxt = S_EXP;
      end
      S_EXP: begin
        step_nxt = step_r + 5'd1;
        if (step_r == EXP_LAST) state_nxt = S_WACC;
      end
      S_WACC: begin
        idx_nxt = idx_r + CW'(1);
        if (idx_r + CW'(1) == n_pts) state_nxt = S_PHASE;
        else state_nxt = S_RD;
      end
      S_PHASE: state_nxt = S_ZINIT;
      S_ZINIT: begin
        step_nxt  = '0;
        state_nxt = S_CORDIC;
      end
      S_CORDIC: begin
        step_nxt = step_r + 5'd1;
        if (step_r == CORDIC_LAST) state_nxt = S_FOLD;
      end
      S_FOLD:  state_nxt = S_AS;
      S_AS:    state_nxt = S_AC;
      S_AC:    state_nxt = S_OMEGA;
      S_OMEGA: state_nxt = S_VMUL;
      S_VMUL:  state_nxt = S_DLO;
      S_DLO:   state_nxt = S_DHI;
      S_DHI:   state_nxt = S_DFIN;
      S_DFIN:  state_nxt = S_VLO;
      S_VLO:   state_nxt = S_VHI;
      S_VHI:   state_nxt = S_VFIN;
      S_VFIN:  state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state, counters and busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      step_r  <= '0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  // Decode state into a datapath operation
  always_comb begin
    cmd.capture = start && !busy_r;
    cmd.idx     = 6'(idx_r);
    cmd.step    = step_r;
    case (state_r)
      S_LOAD:   cmd.op = OP_LOAD;
      S_BOUNDS: cmd.op = OP_BOUNDS;
      S_RD:     cmd.op = OP_RD;
      S_DIFF:   cmd.op = OP_DIFF;
      S_SQX:    cmd.op = OP_SQX;
      S_SQY:    cmd.op = OP_SQY;
      S_PLO:    cmd.op = OP_PLO;
      S_PHI:    cmd.op = OP_PHI;
      S_ACHK:   cmd.op = OP_ACHK;
      S_EXP:    cmd.op = OP_EXP;
      S_WACC:   cmd.op = OP_WACC;
      S_PHASE:  cmd.op = OP_PHASE;
      S_ZINIT:  cmd.op = OP_ZINIT;
      S_CORDIC: cmd.op = OP_CORDIC;
      S_FOLD:   cmd.op = OP_FOLD;
      S_AS:     cmd.op = OP_AS;
      S_AC:     cmd.op = OP_AC;
      S_OMEGA:  cmd.op = OP_OMEGA;
      S_VMUL:   cmd.op = OP_VMUL;
      S_DLO:    cmd.op = OP_DLO;
      S_DHI:    cmd.op = OP_DHI;
      S_DFIN:   cmd.op = OP_DFIN;
      S_VLO:    cmd.op = OP_VLO;
      S_VHI:    cmd.op = OP_VHI;
      S_VFIN:   cmd.op = OP_VFIN;
      S_OUT:    cmd.op = OP_OUT;
      default:  cmd.op = OP_NOP;
    endcase
  end

  assign busy = busy_r;

endmodule
`default_nettype wire

>>> sv/grbf_dp.sv
// Datapath of the RBF evaluator: point stores, distance and exp unit,
// CORDIC, amplitude products and result registers. Depends on grbf_pkg.
`default_nettype none
module grbf_dp import grbf_pkg::*; #(
  parameter int MAX_POINTS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  cmd_t             cmd,
  input  cfg_t             cfg,
  input  wire logic [1:0]  in_func,
  input  wire logic [4:0]  in_entry_index,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_pos_z,
  input  wire logic [31:0] in_time_now,
  input  wire logic [31:0] in_weight_value,
  output sts_t             sts,
  output logic             out_valid,
  output logic [31:0]      out_displacement_y,
  output logic [31:0]      out_velocity_y,
  output logic             out_in_domain,
  output logic             out_in_window
);

  localparam int IW = $clog2(MAX_POINTS);

  // Point and weight stores
  logic [31:0] mem_x [MAX_POINTS];
  logic [31:0] mem_y [MAX_POINTS];
  logic [31:0] mem_w [MAX_POINTS];

  logic [1:0]  func_r;
  logic [4:0]  eidx_r;
  logic [31:0] px_r, py_r, pz_r, t_r, w_in_r;
  logic        dom_r, win_r, ge_r;
  logic [31:0] rdx_r, rdy_r, rdw_r;
  logic [31:0] ux_r, uy_r;
  logic [63:0] sq_r, d2_r;
  logic [51:0] plo_r;
  logic [48:0] phi_r;
  logic        big_r;
  logic [20:0] a_r;
  logic [30:0] r_r;
  logic signed [39:0] sum_r;
  logic [31:0] phase_r;
  logic [1:0]  q_r;
  logic signed [33:0] x_r, y_r, c_r, s_r;
  logic signed [32:0] z_r;
  logic [32:0] asm_r, acm_r;
  logic        as_neg_r, ac_neg_r;
  logic [34:0] omega_r;
  logic [47:0] vmag_r;
  logic [67:0] pl_r, ph_r;
  logic [31:0] disp_r, vel_r;
  logic        out_valid_r, dom_out_r, win_out_r;
  logic [31:0] disp_out_r, vel_out_r;

  // Combinational helpers
  logic signed [32:0] dx, dy;
  logic [64:0]  sq_sum;
  logic [52:0]  tot;
  logic [4:0]   abit;
  logic [61:0]  ep;
  logic [32:0]  wm;
  logic [63:0]  wp;
  logic [31:0]  mt, te;
  logic [63:0]  php;
  logic [60:0]  zp;
  logic signed [33:0] xs, ys, at;
  logic signed [32:0] ampx;
  logic [32:0]  amp_m;
  logic [33:0]  s_m, c_m;
  logic [66:0]  ap_s, ap_c;
  logic [63:0]  om_p;
  logic [67:0]  vp;
  logic [39:0]  sum_m;
  logic [47:0]  mul_b;
  logic [19:0]  mul_a;
  logic [87:0]  pfull;
  logic         eval_item;

  always_comb begin
    dx     = $signed({px_r[31], px_r}) - $signed({rdx_r[31], rdx_r});
    dy     = $signed({py_r[31], py_r}) - $signed({rdy_r[31], rdy_r});
    sq_sum = {1'b0, sq_r} + {1'b0, 64'(uy_r) * 64'(uy_r)};
    tot    = 53'(plo_r) + {16'b0, phi_r[16:0], 20'b0};
    abit   = (cmd.step < 5'd16) ? (5'd15 - cmd.step) : cmd.step;
    ep     = 62'(r_r) * 62'(exp_factor(cmd.step));
    wm     = rdw_r[31] ? (33'd0 - {1'b1, rdw_r}) : {1'b0, rdw_r};
    wp     = 64'(wm) * 64'(r_r);
    mt     = (t_r < cfg.t_end) ? t_r : cfg.t_end;
    te     = mt - cfg.t_start;
    php    = 64'(cfg.freq) * 64'(te);
    zp     = 61'(phase_r[29:0]) * 61'(HALF_PI_Q30);
    xs     = x_r >>> cmd.step;
    ys     = y_r >>> cmd.step;
    at     = $signed({3'b0, atan_q30(cmd.step)});
    ampx   = $signed({cfg.amp[31], cfg.amp});
    amp_m  = ampx[32] ? 33'(-ampx) : 33'(ampx);
    s_m    = s_r[33] ? 34'(-s_r) : 34'(s_r);
    c_m    = c_r[33] ? 34'(-c_r) : 34'(c_r);
    ap_s   = 67'(amp_m) * 67'(s_m);
    ap_c   = 67'(amp_m) * 67'(c_m);
    om_p   = 64'(cfg.freq) * 64'(TWO_PI_Q29);
    vp     = 68'(acm_r) * 68'(omega_r);
    sum_m  = sum_r[39] ? 40'(-sum_r) : 40'(sum_r);
    mul_b  = (cmd.op == OP_DLO || cmd.op == OP_DHI) ? 48'(asm_r) : vmag_r;
    mul_a  = (cmd.op == OP_DHI || cmd.op == OP_VHI) ? sum_m[39:20] : sum_m[19:0];
    pfull  = 88'(pl_r) + (88'(ph_r) << 20);
    eval_item = (func_r == FUNC_EVAL);
  end

  // Write and read the stores
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && int'(eidx_r) < MAX_POINTS) begin
      if (func_r == FUNC_LOAD_POINT) begin
        mem_x[IW'(eidx_r)] <= px_r;
        mem_y[IW'(eidx_r)] <= py_r;
      end else begin
        mem_w[IW'(eidx_r)] <= w_in_r;
      end
    end
    if (cmd.op == OP_RD) begin
      rdx_r <= mem_x[cmd.idx[IW-1:0]];
      rdy_r <= mem_y[cmd.idx[IW-1:0]];
      rdw_r <= mem_w[cmd.idx[IW-1:0]];
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      eidx_r <= in_entry_index;
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      pz_r   <= in_pos_z;
      t_r    <= in_time_now;
      w_in_r <= in_weight_value;
    end
  end

  // Arithmetic steps
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_BOUNDS: begin
        dom_r <= ($signed(px_r) >= $signed(cfg.x_min)) && ($signed(px_r) <= $signed(cfg.x_max))
              && ($signed(py_r) >= $signed(cfg.y_min)) && ($signed(py_r) <= $signed(cfg.y_max))
              && ($signed(pz_r) >= $signed(cfg.z_min)) && ($signed(pz_r) <= $signed(cfg.z_max));
        win_r <= (t_r >= cfg.t_start) && (t_r <= cfg.t_end);
        ge_r  <= (t_r >= cfg.t_start);
        sum_r <= '0;
      end
      OP_DIFF: begin
        ux_r <= dx[32] ? 32'(-dx) : dx[31:0];
        uy_r <= dy[32] ? 32'(-dy) : dy[31:0];
      end
      OP_SQX: sq_r <= 64'(ux_r) * 64'(ux_r);
      OP_SQY: d2_r <= sq_sum[64] ? '1 : sq_sum[63:0];
      OP_PLO: begin
        plo_r <= 52'(cfg.basis) * 52'(d2_r[35:16]);
        big_r <= (d2_r[63:53] != '0) && (cfg.basis != '0);
      end
      OP_PHI: phi_r <= 49'(cfg.basis) * 49'(d2_r[52:36]);
      OP_ACHK: begin
        a_r <= tot[36:16];
        if (big_r || phi_r[48:17] != '0 || tot[52:37] != '0) r_r <= '0;
        else r_r <= ONE_Q30;
      end
      OP_EXP: if (a_r[abit]) r_r <= ep[60:30];
      OP_WACC: begin
        if (rdw_r[31]) sum_r <= sum_r - $signed(40'(wp[62:30]));
        else sum_r <= sum_r + $signed(40'(wp[62:30]));
      end
      OP_PHASE: phase_r <= php[31:0];
      OP_ZINIT: begin
        z_r <= $signed({2'b0, zp[60:30]});
        q_r <= phase_r[31:30];
        x_r <= CORDIC_GAIN_Q30;
        y_r <= '0;
      end
      OP_CORDIC: begin
        if (!z_r[32]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - 33'(at);
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + 33'(at);
        end
      end
      OP_FOLD: begin
        case (q_r)
          2'd0: begin c_r <= x_r;  s_r <= y_r;  end
          2'd1: begin c_r <= -y_r; s_r <= x_r;  end
          2'd2: begin c_r <= -x_r; s_r <= -y_r; end
          default: begin c_r <= y_r; s_r <= -x_r; end
        endcase
      end
      OP_AS: begin
        asm_r    <= ap_s[62:30];
        as_neg_r <= ampx[32] ^ s_r[33];
      end
      OP_AC: begin
        acm_r    <= ap_c[62:30];
        ac_neg_r <= ampx[32] ^ c_r[33];
      end
      OP_OMEGA: omega_r <= om_p[63:29];
      OP_VMUL:  vmag_r <= (vp[67:63] != '0) ? 48'h8000_0000_0000 :
                          ((vp[62:16] > 47'h7FFF_FFFF_FFFF) ? 48'h8000_0000_0000 :
                           48'(vp[62:16]));
      OP_DLO, OP_VLO: pl_r <= 68'(mul_b) * 68'(mul_a);
      OP_DHI, OP_VHI: ph_r <= 68'(mul_b) * 68'(mul_a);
      OP_DFIN: disp_r <= sat_signed(sum_r[39] ^ as_neg_r, pfull[87:16]);
      OP_VFIN: vel_r  <= sat_signed(sum_r[39] ^ ac_neg_r, pfull[87:16]);
      default: ;
    endcase
  end

  // Drive the result beat for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == OP_OUT);
    end
    if (cmd.op == OP_OUT) begin
      dom_out_r  <= eval_item && dom_r;
      win_out_r  <= eval_item && win_r;
      disp_out_r <= (eval_item && dom_r && ge_r) ? disp_r : '0;
      vel_out_r  <= (eval_item && dom_r && win_r) ? vel_r : '0;
    end
  end

  assign sts.func           = func_r;
  assign sts.dom            = dom_r;
  assign out_valid          = out_valid_r;
  assign out_displacement_y = disp_out_r;
  assign out_velocity_y     = vel_out_r;
  assign out_in_domain      = dom_out_r;
  assign out_in_window      = win_out_r;

endmodule
`default_nettype wire

>>> sv/gaussian_rbf_displacement_eval.sv
// Top level of the Gaussian RBF displacement evaluator.
// Depends on grbf_pkg, grbf_regs, grbf_ctrl and grbf_dp.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   input    | start / busy         | in_func, in_entry_index, in_pos_*, ...
//   result   | out_valid strobe     | out_displacement_y, out_velocity_y, flags
//   config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A beat is taken when start is high and busy is low. A load, or an evaluation outside
// the bounds, skips the point walk and the CORDIC. An evaluation of N summed points
// walks, for each point, the distance products and 21 exp steps, then 30 CORDIC steps
// once. The result strobe lasts one cycle and cannot be held off; reset is synchronous,
// and config is taken in every cycle (cfg_ready is always high).
`default_nettype none
module gaussian_rbf_displacement_eval import grbf_pkg::*; #(
  parameter int MAX_POINTS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [4:0]  in_entry_index,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_pos_z,
  input  wire logic [31:0] in_time_now,
  input  wire logic [31:0] in_weight_value,
  output logic             out_valid,
  output logic [31:0]      out_displacement_y,
  output logic [31:0]      out_velocity_y,
  output logic             out_in_domain,
  output logic             out_in_window,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Always accept config beats
  assign cfg_ready = 1'b1;

  grbf_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  grbf_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .pcount (cfg.pcount),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  grbf_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg                (cfg),
    .in_func            (in_func),
    .in_entry_index     (in_entry_index),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_time_now        (in_time_now),
    .in_weight_value    (in_weight_value),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_displacement_y (out_displacement_y),
    .out_velocity_y     (out_velocity_y),
    .out_in_domain      (out_in_domain),
    .out_in_window      (out_in_window)
  );

endmodule
`default_nettype wire
